[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define BRA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bra_pkg.sv]
package bra_pkg;

	localparam int MAX_BITS  = 4096;
	localparam int WORD_BITS = 32;
	localparam int MAP_WORDS = MAX_BITS / WORD_BITS;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int LANE_W    = $clog2(WORD_BITS);
	localparam int IDX_W     = $clog2(MAX_BITS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int KIND_W    = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE      = 3'd0,
		KIND_READ       = 3'd1,
		KIND_FIND_FIRST = 3'd2,
		KIND_FIND_LAST  = 3'd3,
		KIND_FILL       = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  bit_index;
		logic              value;
		logic [CNT_W-1:0]  run_length;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
		logic             bit_value;
		logic [CNT_W-1:0] ones_count;
		logic [CNT_W-1:0] zeros_count;
	} rsp_t;

	// Access request from the sequencer to the map memory.
	typedef struct packed {
		logic                 rd_en;
		logic [WORD_AW-1:0]   rd_addr;
		logic                 wr_en;
		logic [WORD_AW-1:0]   wr_addr;
		logic [WORD_BITS-1:0] wr_data;
		logic                 wipe;
		logic                 wipe_fill;
	} mem_req_t;

	// Outcome of scanning one word.
	typedef struct packed {
		logic             hit;
		logic [LANE_W-1:0] lane;
		logic [CNT_W-1:0] run_out;
	} scan_res_t;

	// Bits of word w that lie below the number of bits in use.
	function automatic logic [WORD_BITS-1:0] word_use_mask(
		input logic [WORD_AW-1:0] w,
		input logic [CNT_W-1:0]   n
	);
		logic [CNT_W-LANE_W-1:0] full_words;
		logic [CNT_W-LANE_W-1:0] wx;
		logic [WORD_BITS-1:0]    mask;
		full_words = n[CNT_W-1:LANE_W];
		wx = (CNT_W-LANE_W)'(w);
		if (wx < full_words) begin
			mask = '1;
		end else if (wx == full_words) begin
			mask = (WORD_BITS'(1) << n[LANE_W-1:0]) - WORD_BITS'(1);
		end else begin
			mask = '0;
		end
		return mask;
	endfunction

endpackage

[rtl/bra_map_mem.sv]
module bra_map_mem import bra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             req,
	input  logic [CNT_W-1:0]     bits_used,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
	logic [WORD_BITS-1:0] raw_q;
	logic [MAP_WORDS-1:0] valid_q;
	logic                 valid_s1;
	logic [WORD_AW-1:0]   addr_s1;
	logic                 fill_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_q   <= mem_q[req.rd_addr];
			addr_s1 <= req.rd_addr;
		end
	end

	// A word never written since the last wipe reads as the fill pattern.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
			fill_q   <= 1'b0;
		end else begin
			if (req.rd_en) begin
				valid_s1 <= valid_q[req.rd_addr];
			end
			if (req.wipe) begin
				valid_q <= '0;
				fill_q  <= req.wipe_fill;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (valid_s1) begin
			rd_data = raw_q;
		end else if (fill_q) begin
			rd_data = word_use_mask(addr_s1, bits_used);
		end else begin
			rd_data = '0;
		end
	end

endmodule

[rtl/bra_run_scan.sv]
module bra_run_scan import bra_pkg::*; (
	input  logic [WORD_BITS-1:0] match,
	input  logic [CNT_W-1:0]     run_in,
	input  logic [CNT_W-1:0]     len,
	output scan_res_t            res
);

	// Each lane works out the length of the matching run that ends on it.
	always_comb begin
		logic [CNT_W-1:0]     run [WORD_BITS];
		logic [WORD_BITS-1:0] hit_v;
		logic                 any_zero;
		logic [LANE_W-1:0]    zpos;
		for (int j = 0; j < WORD_BITS; j++) begin
			any_zero = 1'b0;
			zpos     = '0;
			for (int k = 0; k < WORD_BITS; k++) begin
				if (k <= j && !match[k]) begin
					any_zero = 1'b1;
					zpos     = LANE_W'(k);
				end
			end
			if (any_zero) begin
				run[j] = CNT_W'(LANE_W'(j) - zpos);
			end else begin
				run[j] = run_in + CNT_W'(j + 1);
			end
			hit_v[j] = (run[j] >= len);
		end
		res.hit  = |hit_v;
		res.lane = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (hit_v[j]) begin
				res.lane = LANE_W'(j);
			end
		end
		res.run_out = run[WORD_BITS-1];
	end

endmodule

[rtl/bitmap_run_allocator_top.sv]
// Allocation bitmap of 4096 bits held as 128 words of 32 bits, with a running
// count of set bits.
// Request channel (req_valid, req_stall, req): an item is taken when req_valid
// is high and req_stall is low. The block works on one item at a time, so
// req_stall stays high from the cycle after an item is taken until its work
// is done. Response channel (rsp_valid, rsp_stall, rsp): every item gives
// exactly one response item, held in an output register until taken.
// Write and read make one memory read; a write then modifies the word and
// writes it back. A search covers the words in use (128 at the full map):
// it reads one word per cycle from the map memory and stops at the first
// hit.
// A stalled response does not hold up the next item: the block takes a new
// item and only waits in its final step until the output register is free.
// Configuration (cfg_valid, cfg_ready, cfg_data) sets the number of bits in
// use and empties the map; it is accepted while the block is idle. While a
// configuration write is offered, req_stall is held high so that the two
// are never taken in the same cycle.
// Reset gives 4096 bits in use and an empty map, with no clearing pass.
module bitmap_run_allocator_top import bra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ACCESS = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [KIND_W-1:0]    kind_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 value_q;
	logic [CNT_W-1:0]     len_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     set_total_q;
	logic [CNT_W-1:0]     run_q;
	logic [WORD_AW-1:0]   iss_addr_q;
	logic [WORD_AW-1:0]   iss_left_q;
	logic                 rdv_s1;
	logic                 last_s1;
	logic [WORD_AW-1:0]   dat_addr_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     pos_q;
	logic                 bitv_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	mem_req_t             mreq;
	logic [WORD_BITS-1:0] rd_data;
	scan_res_t            sres;

	logic                 accept;
	logic                 cfg_fire;
	logic                 search_null;
	logic [CNT_W-1:0]     n_m1;
	logic [WORD_AW-1:0]   last_word;
	logic [WORD_AW-1:0]   start_addr;
	logic [WORD_AW-1:0]   next_addr;
	logic                 issue_now;
	logic [WORD_BITS-1:0] used_bits;
	logic [WORD_BITS-1:0] match_fwd;
	logic [WORD_BITS-1:0] match;
	logic [IDX_W-1:0]     pos_first;
	logic [IDX_W-1:0]     pos_last;
	logic [CNT_W-1:0]     pos_sum;
	logic [WORD_BITS-1:0] bit_mask;
	logic                 cur_bit;
	logic                 in_range;
	logic [CNT_W-1:0]     cfg_bits;
	logic                 rsp_load;

	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// A register value beyond the map size acts as the full map.
	assign cfg_bits = (cfg_data > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : cfg_data;

	// Searches with an empty map or a zero run length answer at once.
	assign search_null = (req.run_length == '0) || (n_q == '0);
	assign n_m1        = n_q - CNT_W'(1);
	assign last_word   = n_m1[CNT_W-2:LANE_W];
	assign start_addr  = (req.kind == KIND_FIND_LAST) ? last_word : '0;
	assign next_addr   = (kind_q == KIND_FIND_LAST) ? (iss_addr_q - WORD_AW'(1))
	                                                : (iss_addr_q + WORD_AW'(1));

	// Bit under the single-bit access held in idx_q.
	assign bit_mask = WORD_BITS'(1) << idx_q[LANE_W-1:0];
	assign cur_bit  = rd_data[idx_q[LANE_W-1:0]];
	assign in_range = (CNT_W'(idx_q) < n_q);

	// Search path: bits past the end of the map count as mismatches, which
	// ends any run there. A downward search scans the word bit-reversed, so
	// one scan unit serves both directions.
	assign used_bits = word_use_mask(dat_addr_s1, n_q);
	assign match_fwd = (value_q ? rd_data : ~rd_data) & used_bits;

	always_comb begin
		for (int k = 0; k < WORD_BITS; k++) begin
			match[k] = (kind_q == KIND_FIND_LAST) ? match_fwd[WORD_BITS-1-k] : match_fwd[k];
		end
	end

	bra_run_scan u_scan (
		.match  (match),
		.run_in (run_q),
		.len    (len_q),
		.res    (sres)
	);

	// An upward hit ends the run on the hit lane, so the run starts len - 1
	// bits lower. A downward hit is itself the start of the run.
	assign pos_sum   = CNT_W'({dat_addr_s1, sres.lane}) + CNT_W'(1) - len_q;
	assign pos_first = pos_sum[IDX_W-1:0];
	assign pos_last  = {dat_addr_s1, ~sres.lane};

	assign issue_now = (state_q == ST_SCAN) && (iss_left_q != '0) && !(rdv_s1 && sres.hit);

	// Memory requests. Items are handled one at a time and a write-back
	// always completes before the next item's read is issued, so no
	// forwarding is needed.
	always_comb begin
		mreq = '0;
		if (cfg_fire) begin
			mreq.wipe      = 1'b1;
			mreq.wipe_fill = 1'b0;
		end else if (accept && req.kind == KIND_FILL) begin
			mreq.wipe      = 1'b1;
			mreq.wipe_fill = req.value;
		end
		if (accept) begin
			case (req.kind)
				KIND_WRITE, KIND_READ: begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = req.bit_index[IDX_W-1:LANE_W];
				end
				KIND_FIND_FIRST, KIND_FIND_LAST: begin
					mreq.rd_en   = !search_null;
					mreq.rd_addr = start_addr;
				end
				default: begin
					mreq.rd_en = 1'b0;
				end
			endcase
		end
		if (state_q == ST_ACCESS && kind_q == KIND_WRITE && in_range) begin
			mreq.wr_en   = 1'b1;
			mreq.wr_addr = idx_q[IDX_W-1:LANE_W];
			mreq.wr_data = value_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
		end
		if (issue_now) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = next_addr;
		end
	end

	bra_map_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mreq),
		.bits_used (n_q),
		.rd_data   (rd_data)
	);

	// The output register is free when empty or being taken this cycle.
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.kind;
			idx_q   <= req.bit_index;
			value_q <= req.value;
			len_q   <= req.run_length;
			pos_q   <= '0;
			bitv_q  <= 1'b0;
			run_q   <= '0;
			iss_addr_q  <= start_addr;
			iss_left_q  <= last_word;
			dat_addr_s1 <= start_addr;
		end
		if (state_q == ST_ACCESS && kind_q == KIND_READ) begin
			bitv_q <= in_range && cur_bit;
		end
		if (issue_now) begin
			iss_addr_q  <= next_addr;
			iss_left_q  <= iss_left_q - WORD_AW'(1);
			dat_addr_s1 <= next_addr;
		end
		if (state_q == ST_SCAN && rdv_s1) begin
			if (sres.hit) begin
				pos_q <= (kind_q == KIND_FIND_LAST) ? pos_last : pos_first;
			end else begin
				run_q <= sres.run_out;
			end
		end
		if (rsp_load) begin
			rsp_q.found       <= found_q;
			rsp_q.position    <= found_q ? pos_q : '0;
			rsp_q.bit_value   <= bitv_q;
			rsp_q.ones_count  <= set_total_q;
			rsp_q.zeros_count <= n_q - set_total_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= CNT_W'(MAX_BITS);
			set_total_q <= '0;
			rdv_s1      <= 1'b0;
			last_s1     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				n_q         <= cfg_bits;
				set_total_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						rdv_s1  <= 1'b0;
						case (req.kind)
							KIND_WRITE, KIND_READ: begin
								state_q <= ST_ACCESS;
							end
							KIND_FIND_FIRST, KIND_FIND_LAST: begin
								if (search_null) begin
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_SCAN;
									rdv_s1  <= 1'b1;
									last_s1 <= (last_word == '0);
								end
							end
							KIND_FILL: begin
								state_q <= ST_RESP;
								if (!cfg_fire) begin
									set_total_q <= req.value ? n_q : '0;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_ACCESS: begin
					if (kind_q == KIND_WRITE && in_range) begin
						if (value_q && !cur_bit) begin
							set_total_q <= set_total_q + CNT_W'(1);
						end else if (!value_q && cur_bit) begin
							set_total_q <= set_total_q - CNT_W'(1);
						end
					end
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					if (issue_now) begin
						rdv_s1  <= 1'b1;
						last_s1 <= (iss_left_q == WORD_AW'(1));
					end else begin
						rdv_s1 <= 1'b0;
					end
					if (rdv_s1) begin
						if (sres.hit) begin
							found_q <= 1'b1;
							state_q <= ST_RESP;
						end else if (last_s1) begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/bra_checker.sv]
`include "assert_macros.svh"

module bra_checker import bra_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_t             rsp,
	input logic             cfg_ready
);

	logic [CNT_W:0] count_sum;

	assign count_sum = {1'b0, rsp.ones_count} + {1'b0, rsp.zeros_count};

	// Set and clear bits together never exceed the map size.
	`BRA_ASSERT_IMP(a_count_bound, clk, arst_n, rsp_valid, count_sum <= (CNT_W+1)'(MAX_BITS), "counts exceed map size")

	// A failed or absent search reports position zero.
	`BRA_ASSERT_IMP(a_pos_zero, clk, arst_n, rsp_valid && !rsp.found, rsp.position == '0, "position set without a hit")

	// A response comes from either a read or a search, never both.
	`BRA_ASSERT_ALWAYS(a_kind_excl, clk, arst_n, !(rsp_valid && rsp.found && rsp.bit_value), "read and search fields both set")

	// One item at a time: a taken item closes the request channel.
	`BRA_ASSERT_NEXT(a_one_item, clk, arst_n, req_valid && !req_stall, req_stall && !cfg_ready, "request taken while busy")

	// A stalled response holds.
	`BRA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (.*);
